// ===== src/lobt_pkg.sv =====
// Package for the limit order book table: sizes, operation and status codes,
// payload structs and the controller/datapath command and status structs. No dependencies.
`default_nettype none
package lobt_pkg;
    localparam int ORDER_SLOTS = 64;
    localparam int SLOT_W = $clog2(ORDER_SLOTS);
    localparam int CNT_W = $clog2(ORDER_SLOTS + 1);

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_MODIFY = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [30:0] order_id;
        logic        side;
        logic [31:0] price;
        logic [31:0] target_price;
        logic [31:0] quantity;
    } lobt_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic       level_emptied;
        logic       book_empty;
        logic [6:0] order_count;
    } lobt_out_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch request, clear scan results
        logic scan;     // examine slot at scan index
        logic commit;   // apply operation using scan results
    } lobt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
    } lobt_stat_t;
endpackage
`default_nettype wire

// ===== src/lobt_datapath.sv =====
// Datapath: slot memory, valid bits, one-slot-per-cycle scan, write-back.
// Depends on lobt_pkg.
`default_nettype none
module lobt_datapath
    import lobt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire lobt_in_t   req,
    input  wire lobt_cmd_t  cmd,
    output lobt_stat_t      stat,
    output lobt_out_t       result
);
    typedef struct packed {
        logic [30:0] order_id;
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
        logic [31:0] arrival;
    } slot_t;

    slot_t                  mem [ORDER_SLOTS];
    logic [ORDER_SLOTS-1:0] valid_reg;
    logic [31:0]            arrival_reg;
    logic [CNT_W-1:0]       count_reg;
    lobt_in_t               req_reg;

    logic [SLOT_W-1:0] idx_reg;      // scan index (read address)
    logic              rd_live_reg;  // rd_reg holds slot rd_idx_reg
    logic [SLOT_W-1:0] rd_idx_reg;
    slot_t             rd_reg;
    logic              rd_last_reg;

    logic              free_hit_reg, match_hit_reg;
    logic [SLOT_W-1:0] free_idx_reg, match_idx_reg;
    logic [31:0]       best_age_reg;
    logic [31:0]       best_arr_reg;   // arrival stamp kept for in-place quantity update
    logic [CNT_W-1:0]  level_cnt_reg;  // valid orders at request side/price

    // read port
    always_ff @(posedge clk)
    begin
        rd_reg <= mem[idx_reg];
    end

    wire logic rd_valid = valid_reg[rd_idx_reg];
    wire logic lvl_hit = rd_valid && rd_reg.side == req_reg.side
                         && rd_reg.price == req_reg.price;
    wire logic id_hit = lvl_hit && rd_reg.order_id == req_reg.order_id;
    wire logic [31:0] age = arrival_reg - rd_reg.arrival;

    assign stat.scan_last = rd_live_reg && rd_last_reg;

    logic [1:0] st;
    logic       emptied, price_move, do_write;
    slot_t      wr;
    logic [SLOT_W-1:0] wr_idx;
    always_comb
    begin
        st = ST_DONE;
        emptied = 1'b0;
        do_write = 1'b0;
        wr_idx = match_idx_reg;
        price_move = req_reg.target_price != req_reg.price;
        wr = '{order_id: req_reg.order_id, side: req_reg.side, price: req_reg.price,
               quantity: req_reg.quantity, arrival: arrival_reg};
        case (req_reg.kind)
            KIND_ADD:
            begin
                if (!free_hit_reg) st = ST_FULL;
                else
                begin
                    do_write = 1'b1;
                    wr_idx = free_idx_reg;
                end
            end
            KIND_REMOVE:
            begin
                if (!match_hit_reg) st = ST_NOT_FOUND;
                else emptied = level_cnt_reg == CNT_W'(1);
            end
            KIND_MODIFY:
            begin
                if (!match_hit_reg) st = ST_NOT_FOUND;
                else
                begin
                    do_write = 1'b1;
                    if (price_move)
                    begin
                        emptied = level_cnt_reg == CNT_W'(1);
                        wr.price = req_reg.target_price;
                    end
                    else
                    begin
                        wr.arrival = best_arr_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    logic [CNT_W-1:0] count_next;
    always_comb
    begin
        count_next = count_reg;
        if (req_reg.kind == KIND_ADD && free_hit_reg) count_next = count_reg + 1'b1;
        if (req_reg.kind == KIND_REMOVE && match_hit_reg) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && do_write) mem[wr_idx] <= wr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            arrival_reg <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            rd_live_reg <= 1'b0;
            rd_idx_reg  <= '0;
            rd_last_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            idx_reg     <= '0;
            rd_live_reg <= 1'b0;
            rd_last_reg <= 1'b0;
        end
        else if (cmd.scan)
        begin
            rd_live_reg <= !rd_last_reg || !rd_live_reg;
            rd_idx_reg  <= idx_reg;
            rd_last_reg <= idx_reg == SLOT_W'(ORDER_SLOTS - 1);
            if (idx_reg != SLOT_W'(ORDER_SLOTS - 1)) idx_reg <= idx_reg + 1'b1;
        end
        else if (cmd.commit)
        begin
            rd_live_reg <= 1'b0;
            count_reg   <= count_next;
            if (req_reg.kind == KIND_ADD && free_hit_reg)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
                arrival_reg <= arrival_reg + 1'b1;
            end
            if (req_reg.kind == KIND_REMOVE && match_hit_reg)
                valid_reg[match_idx_reg] <= 1'b0;
            if (req_reg.kind == KIND_MODIFY && match_hit_reg && price_move)
                arrival_reg <= arrival_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg       <= req;
            free_hit_reg  <= 1'b0;
            match_hit_reg <= 1'b0;
            level_cnt_reg <= '0;
        end
        else if (cmd.scan && rd_live_reg)
        begin
            if (!rd_valid && !free_hit_reg)
            begin
                free_hit_reg <= 1'b1;
                free_idx_reg <= rd_idx_reg;
            end
            if (lvl_hit) level_cnt_reg <= level_cnt_reg + 1'b1;
            // strictly older wins; ties keep the lower index
            if (id_hit && (!match_hit_reg || age > best_age_reg))
            begin
                match_hit_reg <= 1'b1;
                match_idx_reg <= rd_idx_reg;
                best_age_reg  <= age;
                best_arr_reg  <= rd_reg.arrival;
            end
        end
        if (cmd.commit)
        begin
            result.status        <= st;
            result.level_emptied <= emptied;
            result.book_empty    <= count_next == '0;
            result.order_count   <= (count_next > CNT_W'(127)) ? 7'd127 : 7'(count_next);
        end
    end
endmodule
`default_nettype wire

// ===== src/lobt_ctrl.sv =====
// Controller FSM: accept item, run slot scan, commit, hold result.
// Depends on lobt_pkg.
`default_nettype none
module lobt_ctrl
    import lobt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire lobt_stat_t stat,
    output lobt_cmd_t       cmd
);
    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT, S_OUT} state_t;
    state_t state_reg;

    assign in_ready   = state_reg == S_IDLE;
    assign out_valid  = state_reg == S_OUT;
    assign cmd.load   = in_valid && in_ready;
    assign cmd.scan   = state_reg == S_SCAN;
    assign cmd.commit = state_reg == S_COMMIT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else
        begin
            unique case (state_reg)
                S_IDLE:   if (in_valid) state_reg <= S_SCAN;
                S_SCAN:   if (stat.scan_last) state_reg <= S_COMMIT;
                S_COMMIT: state_reg <= S_OUT;
                S_OUT:    if (out_ready) state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.scan, cmd.commit})) else $error("cmd overlap");
    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid) else $error("commit without result");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule
`default_nettype wire

// ===== src/limit_order_book_table_core.sv =====
// Top level of the limit order book table: controller plus datapath.
// Depends on lobt_pkg, lobt_ctrl, lobt_datapath.
`default_nettype none
// One item at a time: after acceptance the 64 slots are read one per cycle
// from the registered slot memory read port, then the commit state writes back
// and registers the result; the next item is taken only once the core is back
// in idle. No clearing pass.
module limit_order_book_table_core
    import lobt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire lobt_in_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output lobt_out_t     out_data
);
    lobt_cmd_t  cmd;
    lobt_stat_t stat;

    lobt_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
    );
    lobt_datapath u_dp (
        .clk, .rst_n, .req(in_data), .cmd, .stat, .result(out_data)
    );
endmodule
`default_nettype wire

// ===== tb/tb_limit_order_book_table_core.sv =====
// Testbench for limit_order_book_table_core: drives add/remove/modify items,
// predicts each result from a local copy of the order table, checks results.
// Depends on lobt_pkg and the limit_order_book_table_core RTL.
`default_nettype none
module tb_limit_order_book_table_core;
    import lobt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int SETTLE_CYCLES = 200;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    lobt_in_t  in_data;
    logic      out_valid;
    logic      out_ready;
    lobt_out_t out_data;

    limit_order_book_table_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // local copy of the order table
    logic        book_valid [ORDER_SLOTS];
    logic [30:0] book_id [ORDER_SLOTS];
    logic        book_side [ORDER_SLOTS];
    logic [31:0] book_price [ORDER_SLOTS];
    logic [31:0] book_qty [ORDER_SLOTS];
    logic [31:0] book_stamp [ORDER_SLOTS];
    logic [31:0] stamp_counter;

    lobt_out_t pending_results[$];
    int  mismatches;
    int  idle_cycles;
    bit  hold_off;
    bit  use_rx_idle;
    bit  use_tx_idle;

    // recently used orders, for well-formed removes and modifies
    logic [30:0] known_id [$];
    logic        known_side [$];
    logic [31:0] known_price [$];

    function automatic int find_oldest_slot(logic [30:0] id, logic sd, logic [31:0] px);
        int best;
        logic [31:0] best_age;
        logic [31:0] age;
        best = -1;
        best_age = '0;
        for (int i = 0; i < ORDER_SLOTS; i++)
        begin
            if (book_valid[i] && book_id[i] == id && book_side[i] == sd
                    && book_price[i] == px)
            begin
                age = stamp_counter - book_stamp[i];
                if (best < 0 || age > best_age)
                begin
                    best = i;
                    best_age = age;
                end
            end
        end
        return best;
    endfunction

    function automatic logic level_occupied(logic sd, logic [31:0] px);
        for (int i = 0; i < ORDER_SLOTS; i++)
            if (book_valid[i] && book_side[i] == sd && book_price[i] == px)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic lobt_out_t apply_order(lobt_in_t op);
        lobt_out_t r;
        int s;
        int n;
        r = '0;
        s = -1;
        n = 0;
        case (op.kind)
            KIND_ADD:
            begin
                for (int i = 0; i < ORDER_SLOTS; i++)
                    if (s < 0 && !book_valid[i])
                        s = i;
                if (s < 0)
                    r.status = ST_FULL;
                else
                begin
                    book_valid[s] = 1'b1;
                    book_id[s] = op.order_id;
                    book_side[s] = op.side;
                    book_price[s] = op.price;
                    book_qty[s] = op.quantity;
                    book_stamp[s] = stamp_counter;
                    stamp_counter++;
                end
            end
            KIND_REMOVE, KIND_MODIFY:
            begin
                s = find_oldest_slot(op.order_id, op.side, op.price);
                if (s < 0)
                    r.status = ST_NOT_FOUND;
                else if (op.kind == KIND_REMOVE)
                begin
                    book_valid[s] = 1'b0;
                    r.level_emptied = !level_occupied(op.side, op.price);
                end
                else if (op.target_price != op.price)
                begin
                    book_valid[s] = 1'b0;
                    r.level_emptied = !level_occupied(op.side, op.price);
                    book_valid[s] = 1'b1;
                    book_price[s] = op.target_price;
                    book_qty[s] = op.quantity;
                    book_stamp[s] = stamp_counter;
                    stamp_counter++;
                end
                else
                    book_qty[s] = op.quantity;
            end
            default: ;
        endcase
        for (int i = 0; i < ORDER_SLOTS; i++)
            if (book_valid[i])
                n++;
        r.book_empty = (n == 0);
        r.order_count = (n > 127) ? 7'd127 : n[6:0];
        return r;
    endfunction

    // valid stays high into the next item when there is no gap
    task automatic send_order(lobt_in_t op);
        int gap;
        gap = use_tx_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= op;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results = {pending_results, apply_order(op)};
        if (op.kind == KIND_ADD || (op.kind == KIND_MODIFY && op.target_price != op.price))
        begin
            known_id = {known_id, op.order_id};
            known_side = {known_side, op.side};
            known_price = {known_price, (op.kind == KIND_ADD) ? op.price : op.target_price};
            if (known_id.size() > 48)
            begin
                void'(known_id.pop_front());
                void'(known_side.pop_front());
                void'(known_price.pop_front());
            end
        end
    endtask

    function automatic lobt_in_t make_order(logic [1:0] k, logic [30:0] id, logic sd,
                                            logic [31:0] px, logic [31:0] npx,
                                            logic [31:0] q);
        lobt_in_t op;
        op.kind = k;
        op.order_id = id;
        op.side = sd;
        op.price = px;
        op.target_price = npx;
        op.quantity = q;
        return op;
    endfunction

    // random item: mostly adds and hits on resting orders, some misses
    function automatic lobt_in_t random_order();
        lobt_in_t op;
        int pick;
        int j;
        op = 130'({$urandom, $urandom, $urandom, $urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 40 || known_id.size() == 0)
        begin
            op.kind = KIND_ADD;
            if ($urandom_range(0, 3) != 0)
                op.price = $urandom_range(0, 7);
            if ($urandom_range(0, 3) != 0)
                op.order_id = 31'($urandom_range(0, 15));
        end
        else if (pick < 92)
        begin
            j = $urandom_range(0, known_id.size() - 1);
            op.kind = ($urandom_range(0, 1) != 0) ? KIND_REMOVE : KIND_MODIFY;
            op.order_id = known_id[j];
            op.side = known_side[j];
            op.price = known_price[j];
            if ($urandom_range(0, 2) == 0)
                op.target_price = op.price;
            else if ($urandom_range(0, 1) != 0)
                op.target_price = $urandom_range(0, 7);
        end
        else if (pick < 97)
        begin
            op.kind = ($urandom_range(0, 1) != 0) ? KIND_REMOVE : KIND_MODIFY;
        end
        else
            op.kind = KIND_UNUSED;
        return op;
    endfunction

    // result checker
    initial
    begin
        lobt_out_t want;
        int gap;
        out_ready = 1'b0;
        mismatches = 0;
        @(posedge rst_n);
        forever
        begin
            gap = use_rx_idle ? $urandom_range(0, 19) : 0;
            if (gap > 0 || hold_off)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
                while (hold_off)
                    @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", out_data);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, out_data);
                end
            end
        end
    end

    // watchdog on cycles without any input or output handshake
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic test_directed_edges();
        send_order(make_order(KIND_REMOVE, 31'd5, 1'b1, 32'd10, '0, '0));
        send_order(make_order(KIND_MODIFY, 31'd5, 1'b1, 32'd10, 32'd11, 32'd1));
        send_order(make_order(KIND_UNUSED, '1, 1'b1, '1, '1, '1));
        send_order(make_order(KIND_ADD, '1, 1'b1, '1, '0, '1));
        send_order(make_order(KIND_ADD, '0, 1'b0, '0, '1, '0));
        send_order(make_order(KIND_ADD, 31'd7, 1'b1, 32'd100, '0, 32'd5));
        send_order(make_order(KIND_ADD, 31'd7, 1'b1, 32'd100, '0, 32'd6));
        send_order(make_order(KIND_ADD, 31'd8, 1'b1, 32'd100, '0, 32'd3));
        // duplicate ids: oldest taken first
        send_order(make_order(KIND_REMOVE, 31'd7, 1'b1, 32'd100, '0, '0));
        send_order(make_order(KIND_MODIFY, 31'd7, 1'b1, 32'd100, 32'd100, 32'd9));
        send_order(make_order(KIND_MODIFY, 31'd7, 1'b1, 32'd100, 32'd200, '1));
        send_order(make_order(KIND_REMOVE, 31'd8, 1'b1, 32'd100, '0, '0));
        send_order(make_order(KIND_REMOVE, 31'd7, 1'b0, 32'd200, '0, '0));
        send_order(make_order(KIND_MODIFY, '1, 1'b1, '1, '0, 32'd2));
        send_order(make_order(KIND_REMOVE, '1, 1'b1, '0, '0, '0));
        send_order(make_order(KIND_REMOVE, '1, 1'b1, '0, '0, '0));
        send_order(make_order(KIND_REMOVE, '0, 1'b0, '0, '0, '0));
        send_order(make_order(KIND_REMOVE, 31'd7, 1'b1, 32'd200, '0, '0));
    endtask

    // fill past capacity; receiver holds off so the core stalls its input
    task automatic test_full_table();
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
        join_none
        for (int i = 0; i < ORDER_SLOTS + 3; i++)
            send_order(make_order(KIND_ADD, i[30:0], i[0], 32'd50 + i[1:0], '0, i));
        // then drain, including ids that never got a slot
        for (int i = 0; i < ORDER_SLOTS + 3; i++)
            send_order(make_order(KIND_REMOVE, i[30:0], i[0], 32'd50 + i[1:0], '0, '0));
    endtask

    task automatic test_random_orders(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 300 == 0)
            begin
                use_tx_idle = $urandom_range(0, 3) != 0;
                use_rx_idle = $urandom_range(0, 3) != 0;
            end
            send_order(random_order());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        hold_off = 1'b0;
        use_tx_idle = 1'b1;
        use_rx_idle = 1'b1;
        stamp_counter = '0;
        for (int i = 0; i < ORDER_SLOTS; i++)
        begin
            book_valid[i] = 1'b0;
            book_id[i] = '0;
            book_side[i] = 1'b0;
            book_price[i] = '0;
            book_qty[i] = '0;
            book_stamp[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_edges();
        test_full_table();
        test_random_orders(1450);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
